// File: rtl/core/fifo_queued_mutex_defines.svh
// Assertion macros used by the mutex lock core.
`ifndef FIFO_QUEUED_MUTEX_DEFINES_SVH
`define FIFO_QUEUED_MUTEX_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property at every clock edge outside reset
`define FQM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every clock edge, reset included
`define FQM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FQM_ASSERT(lbl, prop, msg)
`define FQM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/core/fqm_pkg.sv
// Types and codes shared by the mutex block.
package fqm_pkg;

    localparam int unsigned TID_W    = 5;
    localparam int unsigned STATUS_W = 3;

    // Opcodes of an input item
    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    // Status codes of a result item
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HANDED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic             opcode;
        logic [TID_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TID_W-1:0]    woken_thread;
        logic                owner_valid;
    } rsp_t;

endpackage

// File: rtl/core/fqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/fqm_lock_core.sv
// Mutex state, waiter ring and the single-pass lock/unlock logic.
module fqm_lock_core #(
    parameter int unsigned MAX_THREADS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  fqm_pkg::req_t item,
    output fqm_pkg::rsp_t rsp
);

    import fqm_pkg::*;

    `include "fifo_queued_mutex_defines.svh"

    localparam int unsigned PW = $clog2(MAX_THREADS);
    localparam int unsigned CW = $clog2(MAX_THREADS + 1);
    localparam int unsigned SW = CW + 1;
    localparam logic [PW-1:0] LAST_SLOT = PW'(MAX_THREADS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_THREADS);
    localparam logic [SW-1:0] WRAP_S    = SW'(MAX_THREADS);

    logic             held_reg, held_next;
    logic [TID_W-1:0] owner_reg, owner_next;
    logic             known_reg, known_next;
    logic [PW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             fwd_valid_reg, fwd_valid_next;
    logic [TID_W-1:0] fwd_data_reg;

    logic             ram_we;
    logic [PW-1:0]    ram_waddr;
    logic [TID_W-1:0] ram_rdata;
    logic [TID_W-1:0] head_val;
    logic [SW-1:0]    tail_sum;
    logic [PW-1:0]    tail;
    logic [PW-1:0]    head_inc;
    logic [PW-1:0]    head_dec;

    // Ring storage; the read port always prefetches the entry at the next head
    fqm_ram #(
        .WIDTH (TID_W),
        .DEPTH (MAX_THREADS)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.thread_id),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    // Take the head entry from the forward register when it was written last cycle
    assign head_val = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    // Ring pointer arithmetic modulo the ring depth
    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= WRAP_S)
        begin
            tail_sum = tail_sum - WRAP_S;
        end
        tail     = tail_sum[PW-1:0];
        head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + PW'(1);
        head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - PW'(1);
    end

    // Work out the next state, ring write and result of one item
    always_comb
    begin
        held_next  = held_reg;
        owner_next = owner_reg;
        known_next = known_reg;
        head_next  = head_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_waddr  = tail;
        rsp.status       = ST_RELEASED;
        rsp.woken_thread = '0;

        if (item_valid)
        begin
            if (item.opcode == OP_LOCK)
            begin
                if (!held_reg)
                begin
                    held_next  = 1'b1;
                    owner_next = item.thread_id;
                    known_next = 1'b1;
                    rsp.status = ST_GRANTED;
                end
                else if (count_reg >= FULL_CNT)
                begin
                    rsp.status = ST_FULL;
                end
                else if (known_reg && (owner_reg == item.thread_id))
                begin
                    // Owner locks again: drop ownership, push to the head
                    head_next  = head_dec;
                    ram_we     = 1'b1;
                    ram_waddr  = head_dec;
                    count_next = count_reg + CW'(1);
                    known_next = 1'b0;
                    owner_next = '0;
                    rsp.status = ST_QUEUED;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = tail;
                    count_next = count_reg + CW'(1);
                    rsp.status = ST_QUEUED;
                end
            end
            else
            begin
                if (held_reg && (count_reg != '0))
                begin
                    // Hand over to the head waiter
                    rsp.woken_thread = head_val;
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                    owner_next = head_val;
                    known_next = 1'b1;
                    rsp.status = ST_HANDED;
                end
                else
                begin
                    held_next  = 1'b0;
                    owner_next = '0;
                    known_next = 1'b0;
                    head_next  = '0;
                    count_next = '0;
                    rsp.status = ST_RELEASED;
                end
            end
        end

        rsp.owner_valid = known_next;
        fwd_valid_next  = ram_we && (ram_waddr == head_next);
    end

    // Hold the mutex state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            owner_reg     <= '0;
            known_reg     <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            owner_reg     <= owner_next;
            known_reg     <= known_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // Capture the head entry when it is written in the cycle it is prefetched
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= item.thread_id;
    end

    `FQM_ASSERT(a_count_bound, count_reg <= FULL_CNT, "waiter count above ring depth")
    `FQM_ASSERT(a_head_bound, head_reg <= LAST_SLOT, "ring head outside ring")
    `FQM_ASSERT(a_owner_held, known_reg |-> held_reg, "owner known while mutex free")
    `FQM_ASSERT(a_free_empty, !held_reg |-> (count_reg == '0), "waiters on a free mutex")
    `FQM_ASSERT(a_grant_owner,
        (item_valid && (rsp.status == ST_GRANTED)) |=> (known_reg && held_reg),
        "grant did not record an owner")

endmodule

// File: rtl/core/fifo_queued_mutex.sv
// Top level of the queued hardware mutex: item and result registers.
//
// Hardware mutex with a first-come queue of waiting thread identifiers.
// One item (lock or unlock) is accepted in every cycle; busy stays low.
// Each item gives exactly one result, shown with result_valid for one
// cycle once the item has passed from the item register through the
// state logic into the result register. The receiver must take every
// result as it appears. The queue holds MAX_THREADS waiters in a ring
// RAM whose read port keeps the head waiter prefetched, so back-to-back
// unlocks each hand over in one pass. A lock to a full queue returns
// "queue full" and changes nothing.
module fifo_queued_mutex #(
    parameter int unsigned MAX_THREADS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fqm_pkg::req_t req,
    output logic          result_valid,
    output fqm_pkg::rsp_t result
);

    import fqm_pkg::*;

    logic in_valid_reg;
    req_t in_item_reg;
    rsp_t core_rsp;
    logic result_valid_reg;
    rsp_t result_reg;

    // Accept an item in every cycle
    assign busy = 1'b0;

    // Item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_item_reg <= req;
        end
    end

    fqm_lock_core #(
        .MAX_THREADS (MAX_THREADS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .rsp        (core_rsp)
    );

    // Result register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= core_rsp;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: dv/tb.sv
// Self-checking testbench of the queued hardware mutex: driver, monitor and predictor.
`timescale 1ns / 1ps

module tb;

    import fqm_pkg::*;

    localparam int unsigned MAX_THREADS  = 32;
    localparam int          RANDOM_ITEMS = 1100;
    localparam int          CALM_FIRST   = 500;
    localparam int          CALM_LAST    = 750;
    localparam int          TAIL_CYCLES  = 8;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef struct {
        req_t item;
        bit   drain;
    } pending_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic result_valid;
    rsp_t result;

    pending_t pending_items[$];
    rsp_t     expected_rsp[$];

    int items_sent   = 0;
    int items_queued = 0;
    int results_seen = 0;
    int errors       = 0;
    int cycles       = 0;
    int status_seen [5];

    // Mutex state as predicted
    logic                 m_held;
    logic [TID_W-1:0]     m_owner;
    logic                 m_owner_known;
    logic [TID_W-1:0]     m_ring [MAX_THREADS];
    logic [TID_W-1:0]     m_head;
    logic [TID_W:0]       m_count;

    fifo_queued_mutex #(
        .MAX_THREADS(MAX_THREADS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .result_valid(result_valid),
        .result      (result)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Apply one lock or unlock to the predicted state and return its result
    function automatic rsp_t mutex_step(req_t r);
        rsp_t             o;
        logic [TID_W-1:0] tail;
        o = '0;
        if (r.opcode == OP_LOCK)
        begin
            if (!m_held)
            begin
                m_held        = 1'b1;
                m_owner       = r.thread_id;
                m_owner_known = 1'b1;
                o.status      = ST_GRANTED;
            end
            else if (m_count >= MAX_THREADS)
            begin
                o.status = ST_FULL;
            end
            else if (m_owner_known && m_owner == r.thread_id)
            begin
                // owner locks again: give up ownership, jump to the head
                m_head         = m_head - 1'b1;
                m_ring[m_head] = r.thread_id;
                m_count        = m_count + 1'b1;
                m_owner_known  = 1'b0;
                m_owner        = '0;
                o.status       = ST_QUEUED;
            end
            else
            begin
                tail         = m_head + m_count[TID_W-1:0];
                m_ring[tail] = r.thread_id;
                m_count      = m_count + 1'b1;
                o.status     = ST_QUEUED;
            end
        end
        else
        begin
            if (m_held && m_count != 0)
            begin
                o.woken_thread = m_ring[m_head];
                m_owner        = m_ring[m_head];
                m_head         = m_head + 1'b1;
                m_count        = m_count - 1'b1;
                m_owner_known  = 1'b1;
                o.status       = ST_HANDED;
            end
            else
            begin
                m_held        = 1'b0;
                m_owner       = '0;
                m_owner_known = 1'b0;
                m_head        = '0;
                m_count       = '0;
                o.status      = ST_RELEASED;
            end
        end
        o.owner_valid = m_owner_known;
        return o;
    endfunction

    task automatic queue_item(logic op, logic [TID_W-1:0] tid, bit drain);
        pending_t p;
        p.item.opcode    = op;
        p.item.thread_id = tid;
        p.drain          = drain;
        pending_items.push_back(p);
        items_queued++;
    endtask

    // Grant, a few contending locks (some by the owner) and unlocks mixed in
    task automatic add_burst(bit drain);
        logic [TID_W-1:0] first;
        int               n;
        int               unlocks;
        first = 5'($urandom_range(31));
        n     = $urandom_range(10);
        queue_item(OP_LOCK, first, drain);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 70)
                queue_item(OP_LOCK, ($urandom_range(3) == 0) ? first : 5'($urandom_range(31)),
                           1'b0);
            else
                queue_item(OP_UNLOCK, 5'($urandom_range(31)), 1'b0);
        end
        unlocks = n - int'($urandom_range(2));
        for (int i = 0; i <= unlocks; i++)
            queue_item(OP_UNLOCK, 5'($urandom_range(31)), 1'b0);
    endtask

    // Fill the queue, knock on it while full (owner too), then drain it
    task automatic add_fill();
        logic [TID_W-1:0] first;
        int               extra;
        first = 5'($urandom_range(31));
        extra = $urandom_range(1, 4);
        queue_item(OP_LOCK, first, 1'b1);
        for (int i = 0; i < MAX_THREADS; i++)
            queue_item(OP_LOCK, 5'(first + 1 + $urandom_range(30)), 1'b0);
        queue_item(OP_LOCK, first, 1'b0);
        for (int i = 0; i < extra; i++)
            queue_item(OP_LOCK, 5'($urandom_range(31)), 1'b0);
        for (int i = 0; i < MAX_THREADS + 2; i++)
            queue_item(OP_UNLOCK, 5'($urandom_range(31)), 1'b0);
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            queue_item(1'($urandom_range(1)), 5'($urandom_range(31)), 1'b0);
    endtask

    // Drive items from the pending queue; idle at random outside the calm stretch
    always @(posedge clk)
    begin : drive_items
        bit idle_now;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_rsp.push_back(mutex_step(req));
                items_sent++;
            end
            if (!(start && busy))
            begin
                idle_now = (items_sent < CALM_FIRST || items_sent >= CALM_LAST)
                           && ($urandom_range(99) < 17);
                if (pending_items.size() != 0 && !idle_now
                    && !(pending_items[0].drain && expected_rsp.size() != 0))
                begin
                    req   <= pending_items[0].item;
                    start <= 1'b1;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("result with no item outstanding: status %0d", result.status);
                errors++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                results_seen++;
                if (result.status <= ST_FULL)
                    status_seen[result.status]++;
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    errors++;
                end
                if (result.woken_thread !== want.woken_thread)
                begin
                    $error("woken_thread: expected %0d, got %0d",
                           want.woken_thread, result.woken_thread);
                    errors++;
                end
                if (result.owner_valid !== want.owner_valid)
                begin
                    $error("owner_valid: expected %0d, got %0d",
                           want.owner_valid, result.owner_valid);
                    errors++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int r;
        int seqs;
        m_held        = 1'b0;
        m_owner       = '0;
        m_owner_known = 1'b0;
        m_head        = '0;
        m_count       = '0;
        foreach (m_ring[i])
            m_ring[i] = '0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed: free unlock, grant, tail queueing, owner relock to head,
        // held without owner, same thread queued twice, handovers, release
        queue_item(OP_UNLOCK, 5'd31, 1'b1);
        queue_item(OP_LOCK,   5'd0,  1'b0);
        queue_item(OP_LOCK,   5'd31, 1'b0);
        queue_item(OP_LOCK,   5'd0,  1'b0);
        queue_item(OP_LOCK,   5'd21, 1'b0);
        queue_item(OP_LOCK,   5'd21, 1'b0);
        queue_item(OP_LOCK,   5'd10, 1'b0);
        for (int i = 0; i < 6; i++)
            queue_item(OP_UNLOCK, 5'(i * 5), 1'b0);
        queue_item(OP_UNLOCK, 5'd0,  1'b0);
        queue_item(OP_LOCK,   5'd31, 1'b0);
        queue_item(OP_UNLOCK, 5'd10, 1'b0);

        // Random: mostly well-formed lock/unlock runs, some full-queue runs, some noise
        add_fill();
        seqs = 0;
        while (items_queued < 16 + RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 4)
                add_fill();
            else if (r < 85)
                add_burst((seqs % 10) == 9);
            else
                add_noise();
            seqs++;
        end

        // Release reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to be taken and every result to arrive
        while (pending_items.size() != 0 || start || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d items and %0d results: %0d granted, %0d queued,",
                 items_sent, results_seen, status_seen[ST_GRANTED], status_seen[ST_QUEUED]);
        $display("%0d handed over, %0d released, %0d dropped on a full queue.",
                 status_seen[ST_HANDED], status_seen[ST_RELEASED], status_seen[ST_FULL]);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
